@@ rtl/gwrs_pkg.sv @@
// Shared types, codes and constants for the grid window reachability search unit.
// Has no dependencies; the top level refers to it by scoped names.
package gwrs_pkg;

  localparam int DEF_MAX_ROWS = 64;
  localparam int DEF_MAX_COLS = 64;

  // Coordinates that the search can ever reach fit in 7 bits: the board is
  // capped by the 7-bit size registers.
  localparam int COORD_W = 7;
  localparam int NBR_W   = COORD_W + 1;
  localparam int CFG_W   = 7;
  localparam int STEP_W  = 4;

  localparam logic [CFG_W-1:0] ROWS_RESET = 7'd64;
  localparam logic [CFG_W-1:0] COLS_RESET = 7'd64;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  localparam logic [7:0] OBSTACLE = 8'h52;

  localparam logic [STEP_W-1:0] LAST_STEP = 4'd8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_POP,
    ST_LOAD,
    ST_NBR,
    ST_CHECK,
    ST_DONE
  } state_t;

  // Row offset of each move, in two's complement on NBR_W bits.
  function automatic logic [NBR_W-1:0] step_dr(input logic [STEP_W-1:0] k);
    logic [NBR_W-1:0] d;
    case (k)
      4'd0, 4'd1, 4'd7: d = 8'h01;
      4'd3, 4'd4, 4'd5: d = 8'hFF;
      default:          d = 8'h00;
    endcase
    return d;
  endfunction

  // Column offset of each move, in two's complement on NBR_W bits.
  function automatic logic [NBR_W-1:0] step_dc(input logic [STEP_W-1:0] k);
    logic [NBR_W-1:0] d;
    case (k)
      4'd1, 4'd2, 4'd3: d = 8'h01;
      4'd5, 4'd6, 4'd7: d = 8'hFF;
      default:          d = 8'h00;
    endcase
    return d;
  endfunction

endpackage

@@ rtl/grid_window_reachability_search_unit.sv @@
// Grid window reachability search unit: grid store, visited map, frontier
// queue and the sequencer that runs the breadth-first search.
// Depends on gwrs_pkg.
//
// Usage. Requests enter on the item channel (item_valid, item_stall). A load
// request (kind = 0) writes cell_value into the grid cell at cell_row,
// cell_col and gives no result. A query request (kind = 1) searches
// from origin_row, origin_col over the 8 neighbors and the cell itself,
// kept inside the board and inside the square window of the given radius,
// never entering cells that hold 'R'. Exactly one result comes out on the
// result channel (result_valid, result_stall): found is 1 when a reached
// cell holds target_char.
// Timing. A query first sweeps the visited map, one entry per cycle.
// Each dequeued cell is then popped from the queue and loaded, and its
// moves are taken in order: a move outside the window is skipped, and a
// move inside it reads the grid and visited memories through their single
// read port and is checked. The search stops early once the target is
// seen. item_stall is high during the whole query.
// The finished result sits in an output register. While the receiver holds
// result_stall, the block keeps accepting load requests, and a following
// query runs and then waits for the register to free up.
// Reset clears the sequencer, the queue pointers and result_valid, and
// sets both board size registers to 64. Grid contents are undefined until
// written. The user must write the size registers through cfg_we only
// while idle; the block itself does not enforce this.
module grid_window_reachability_search_unit #(
  parameter int MAX_ROWS = gwrs_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = gwrs_pkg::DEF_MAX_COLS
) (
  input  logic                      clk,
  input  logic                      rst,
  // Configuration write port.
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [gwrs_pkg::CFG_W-1:0] cfg_data,
  // Request channel.
  input  logic                      item_valid,
  output logic                      item_stall,
  input  logic                      kind,
  input  logic [5:0]                cell_row,
  input  logic [5:0]                cell_col,
  input  logic [7:0]                cell_value,
  input  logic [5:0]                origin_row,
  input  logic [5:0]                origin_col,
  input  logic [5:0]                radius,
  input  logic [7:0]                target_char,
  // Result channel.
  output logic                      result_valid,
  input  logic                      result_stall,
  output logic                      found
);

  localparam int CW     = gwrs_pkg::COORD_W;
  localparam int NW     = gwrs_pkg::NBR_W;
  localparam int CELLS  = MAX_ROWS * MAX_COLS;
  localparam int GA_W   = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int QDEPTH = CELLS + 2;
  localparam int QA_W   = $clog2(QDEPTH);
  localparam int ROW_CAP_I = (MAX_ROWS > 127) ? 127 : MAX_ROWS;
  localparam int COL_CAP_I = (MAX_COLS > 127) ? 127 : MAX_COLS;
  localparam logic [CW-1:0] ROW_CAP = CW'(ROW_CAP_I);
  localparam logic [CW-1:0] COL_CAP = CW'(COL_CAP_I);

  gwrs_pkg::state_t state, state_next;

  // Configuration registers.
  logic [gwrs_pkg::CFG_W-1:0] rows_in_use;
  logic [gwrs_pkg::CFG_W-1:0] cols_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= gwrs_pkg::ROWS_RESET;
      cols_in_use <= gwrs_pkg::COLS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        gwrs_pkg::REG_ROWS: rows_in_use <= cfg_data;
        gwrs_pkg::REG_COLS: cols_in_use <= cfg_data;
        default: ;
      endcase
    end
  end

  logic item_take, load_take, query_take;
  assign item_stall = (state != gwrs_pkg::ST_IDLE);
  assign item_take  = item_valid && !item_stall;
  assign load_take  = item_take && (kind == gwrs_pkg::KIND_LOAD);
  assign query_take = item_take && (kind == gwrs_pkg::KIND_QUERY);

  // Window of the query, already clipped to the board. A row r is inside
  // when win_rlo <= r < win_rlim; same for columns.
  logic [CW-1:0] eff_rows, eff_cols;
  logic [CW-1:0] rlo_c, clo_c, rhi_c, chi_c;
  logic [CW-1:0] win_rlo, win_rlim, win_clo, win_clim;
  logic [7:0]    target;

  assign eff_rows = (32'(rows_in_use) > MAX_ROWS) ? ROW_CAP : rows_in_use;
  assign eff_cols = (32'(cols_in_use) > MAX_COLS) ? COL_CAP : cols_in_use;
  assign rlo_c = (origin_row >= radius) ? CW'(origin_row - radius) : '0;
  assign clo_c = (origin_col >= radius) ? CW'(origin_col - radius) : '0;
  assign rhi_c = CW'(origin_row) + CW'(radius) + CW'(1);
  assign chi_c = CW'(origin_col) + CW'(radius) + CW'(1);

  always_ff @(posedge clk) begin
    if (query_take) begin
      win_rlo  <= rlo_c;
      win_clo  <= clo_c;
      win_rlim <= (rhi_c < eff_rows) ? rhi_c : eff_rows;
      win_clim <= (chi_c < eff_cols) ? chi_c : eff_cols;
      target   <= target_char;
    end
  end

  // Sequencer registers.
  logic [GA_W-1:0]            clr_addr;
  logic [QA_W-1:0]            head, tail;
  logic [gwrs_pkg::STEP_W-1:0] k;
  logic [CW-1:0]              r0, c0;
  logic [CW-1:0]              nbr_r, nbr_c;
  logic [GA_W-1:0]            nbr_idx;
  logic                       found_res;

  // Current move, computed from the cell being expanded.
  logic [NW-1:0]   mv_r, mv_c;
  logic            mv_in;
  logic [GA_W-1:0] mv_idx;

  assign mv_r  = {1'b0, r0} + gwrs_pkg::step_dr(k);
  assign mv_c  = {1'b0, c0} + gwrs_pkg::step_dc(k);
  // A step below zero wraps to a large value and fails the upper bound.
  assign mv_in = (mv_r >= {1'b0, win_rlo}) && (mv_r < {1'b0, win_rlim}) &&
                 (mv_c >= {1'b0, win_clo}) && (mv_c < {1'b0, win_clim});
  assign mv_idx = GA_W'(32'(mv_r[CW-1:0]) * MAX_COLS + 32'(mv_c[CW-1:0]));

  // Memories: grid store, visited map and frontier queue.
  logic [7:0]        grid_mem [CELLS];
  logic              vis_mem  [CELLS];
  logic [2*CW-1:0]   queue_mem [QDEPTH];
  logic [7:0]        grid_q;
  logic              vis_q;
  logic [2*CW-1:0]   queue_q;

  logic              grid_rd, queue_rd;
  logic              vis_we;
  logic [GA_W-1:0]   vis_waddr;
  logic              vis_wdata;
  logic              queue_we;
  logic [QA_W-1:0]   queue_waddr;
  logic [2*CW-1:0]   queue_wdata;
  logic              load_ok;
  logic [GA_W-1:0]   load_addr;

  assign load_ok   = (32'(cell_row) < MAX_ROWS) && (32'(cell_col) < MAX_COLS);
  assign load_addr = GA_W'(32'(cell_row) * MAX_COLS + 32'(cell_col));

  always_ff @(posedge clk) begin
    if (load_take && load_ok) begin
      grid_mem[load_addr] <= cell_value;
    end
    if (grid_rd) begin
      grid_q <= grid_mem[mv_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (vis_we) begin
      vis_mem[vis_waddr] <= vis_wdata;
    end
    if (grid_rd) begin
      vis_q <= vis_mem[mv_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (queue_we) begin
      queue_mem[queue_waddr] <= queue_wdata;
    end
    if (queue_rd) begin
      queue_q <= queue_mem[head];
    end
  end

  // A cell that passes all checks is queued and marked visited.
  logic cand_block, cand_hit, cand_push;
  assign cand_block = (grid_q == gwrs_pkg::OBSTACLE) || vis_q;
  assign cand_hit   = !cand_block && (grid_q == target);
  assign cand_push  = !cand_block && (grid_q != target);

  logic out_free;
  assign out_free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gwrs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    grid_rd     = 1'b0;
    queue_rd    = 1'b0;
    vis_we      = 1'b0;
    vis_waddr   = clr_addr;
    vis_wdata   = 1'b0;
    queue_we    = 1'b0;
    queue_waddr = tail;
    queue_wdata = {nbr_r, nbr_c};
    case (state)
      gwrs_pkg::ST_IDLE: begin
        if (query_take) begin
          queue_we    = 1'b1;
          queue_waddr = '0;
          queue_wdata = {CW'(origin_row), CW'(origin_col)};
          state_next  = gwrs_pkg::ST_CLEAR;
        end
      end
      gwrs_pkg::ST_CLEAR: begin
        vis_we = 1'b1;
        if (clr_addr == GA_W'(CELLS - 1)) begin
          state_next = gwrs_pkg::ST_POP;
        end
      end
      gwrs_pkg::ST_POP: begin
        if (head == tail) begin
          state_next = gwrs_pkg::ST_DONE;
        end else begin
          queue_rd   = 1'b1;
          state_next = gwrs_pkg::ST_LOAD;
        end
      end
      gwrs_pkg::ST_LOAD: begin
        state_next = gwrs_pkg::ST_NBR;
      end
      gwrs_pkg::ST_NBR: begin
        if (mv_in) begin
          grid_rd    = 1'b1;
          state_next = gwrs_pkg::ST_CHECK;
        end else if (k == gwrs_pkg::LAST_STEP) begin
          state_next = gwrs_pkg::ST_POP;
        end
      end
      gwrs_pkg::ST_CHECK: begin
        if (cand_hit) begin
          state_next = gwrs_pkg::ST_DONE;
        end else begin
          if (cand_push) begin
            queue_we  = 1'b1;
            vis_we    = 1'b1;
            vis_waddr = nbr_idx;
            vis_wdata = 1'b1;
          end
          state_next = (k == gwrs_pkg::LAST_STEP) ? gwrs_pkg::ST_POP : gwrs_pkg::ST_NBR;
        end
      end
      gwrs_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = gwrs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = gwrs_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath registers of the sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      tail     <= '0;
      clr_addr <= '0;
    end else begin
      if (query_take) begin
        head     <= '0;
        tail     <= QA_W'(1);
        clr_addr <= '0;
      end
      if (state == gwrs_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + GA_W'(1);
      end
      if (queue_rd) begin
        head <= head + QA_W'(1);
      end
      if (state == gwrs_pkg::ST_CHECK && cand_push) begin
        tail <= tail + QA_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (query_take) begin
      found_res <= 1'b0;
    end
    if (state == gwrs_pkg::ST_LOAD) begin
      r0 <= queue_q[2*CW-1:CW];
      c0 <= queue_q[CW-1:0];
      k  <= '0;
    end
    if (state == gwrs_pkg::ST_NBR) begin
      nbr_r   <= mv_r[CW-1:0];
      nbr_c   <= mv_c[CW-1:0];
      nbr_idx <= mv_idx;
      if (!mv_in) begin
        k <= k + gwrs_pkg::STEP_W'(1);
      end
    end
    if (state == gwrs_pkg::ST_CHECK) begin
      k <= k + gwrs_pkg::STEP_W'(1);
      if (cand_hit) begin
        found_res <= 1'b1;
      end
    end
  end

  // Output register: frees the block while the receiver stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == gwrs_pkg::ST_DONE && out_free) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == gwrs_pkg::ST_DONE && out_free) begin
      found <= found_res;
    end
  end

  // A query always starts with the visited sweep.
  a_query_clears: assert property (@(posedge clk) disable iff (rst)
    query_take |=> state == gwrs_pkg::ST_CLEAR)
    else $error("query did not start with the visited sweep");

  // The queue never underflows while popping.
  a_head_le_tail: assert property (@(posedge clk) disable iff (rst)
    state == gwrs_pkg::ST_POP |-> head <= tail)
    else $error("frontier queue head passed its tail");

  // Every grid read is for a cell inside the clipped window.
  a_check_in_window: assert property (@(posedge clk) disable iff (rst)
    state == gwrs_pkg::ST_CHECK |->
      nbr_r >= win_rlo && nbr_r < win_rlim && nbr_c >= win_clo && nbr_c < win_clim)
    else $error("grid read outside the search window");

  // A result is only loaded when the output register is free.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(found))
    else $error("pending result was overwritten");

endmodule
